// ===== hw/rtl/tglw_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Text glyph layout package
// Shared types, register indexes and constants of the glyph layout block.
// ---------------------------------------------------------------------------
package tglw_pkg;

  // Configuration register indexes.
  localparam logic [2:0] RegCharWidth  = 3'd0;
  localparam logic [2:0] RegLineHeight = 3'd1;
  localparam logic [2:0] RegWrapWidth  = 3'd2;
  localparam logic [2:0] RegAlignMode  = 3'd3;
  localparam logic [2:0] RegStartX     = 3'd4;
  localparam logic [2:0] RegStartY     = 3'd5;

  // Alignment codes; any other code aligns left.
  localparam logic [1:0] AlignMiddle = 2'd1;
  localparam logic [1:0] AlignRight  = 2'd2;

  // Character codes.
  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharSpace   = 8'd32;
  localparam logic [7:0] GlyphBase   = 8'd32;

  // Register reset values.
  localparam logic [6:0]  ResetCharWidth  = 7'd6;
  localparam logic [7:0]  ResetLineHeight = 8'd9;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [6:0]         glyph_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               last_glyph;
  } out_t;

  typedef enum logic [3:0] {
    StIdle,
    StChar,
    StNlChar,
    StWrap,
    StNlWrap,
    StFull,
    StEot,
    StAlign,
    StEmit,
    StLast
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic append;
    logic add_width;
    logic open_word;
    logic close_word;
    logic clear_word;
    logic start_all;
    logic start_word;
    logic align;
    logic emit_glyph;
    logic newline;
    logic flush_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic printable;
    logic is_word;
    logic is_space;
    logic is_newline;
    logic wrap_off;
    logic lw_zero;
    logic overflow;
    logic word_open;
    logic wb_zero;
    logic full;
    logic eot;
    logic emit_done;
    logic can_push;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/text_glyph_layout_wrap.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Text glyph layout with word wrap
// Lays out a byte stream as glyph placements with optional greedy wrapping.
// ---------------------------------------------------------------------------
// Usage: the input channel takes one text byte per beat (char_code and an
// end_of_text flag); the output channel returns glyph placements (index, x, y)
// and marks the last glyph caused by an input byte with last_glyph.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// by the user only while the block is idle; the block does not enforce it.
// Timing: an input byte that only buffers a glyph still passes the
// controller's check steps before the next byte is accepted. A flush for a
// full buffer or end of text aligns and then emits its glyphs; a flush for a
// control byte or a wrap break adds the newline step to this.
// All of this is set by the controller's steps and the single read port of
// the segment buffer. A glyph reaches the output one glyph later than it is
// read, or at the end of the item's processing, since it is held until it is
// known whether it is the last one.
// Reset clears the segment, loads the register defaults and puts the pen at
// the start position. A stalled output holds its beat and glyph emission
// waits; the input stalls until the current byte is fully processed.
// ---------------------------------------------------------------------------
module text_glyph_layout_wrap #(
  parameter int unsigned SEGMENT_MAX = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [15:0]   cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire tglw_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tglw_pkg::out_t     out_data_o
);

  tglw_pkg::cmd_t cmd;
  tglw_pkg::sts_t sts;

  // Controller.
  tglw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  tglw_dpath #(
    .SEGMENT_MAX (SEGMENT_MAX)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/tglw_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Glyph layout controller
// Sequences character handling, wrap checks, flushes and glyph emission.
// ---------------------------------------------------------------------------
module tglw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire tglw_pkg::sts_t sts_i,
  output tglw_pkg::cmd_t     cmd_o
);

  tglw_pkg::state_e state_q, state_d;
  tglw_pkg::state_e ret_q, ret_d;

  // State and return registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tglw_pkg::StIdle;
      ret_q   <= tglw_pkg::StIdle;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  assign in_stall_o = (state_q != tglw_pkg::StIdle);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cmd_o   = '0;
    case (state_q)
      tglw_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tglw_pkg::StChar;
        end
      end
      tglw_pkg::StChar: begin
        if (sts_i.wrap_off) begin
          cmd_o.close_word = 1'b1;
          if (sts_i.printable) begin
            cmd_o.append = 1'b1;
            state_d      = tglw_pkg::StWrap;
          end else begin
            cmd_o.start_all = 1'b1;
            ret_d           = tglw_pkg::StNlChar;
            state_d         = tglw_pkg::StAlign;
          end
        end else if (sts_i.is_word) begin
          cmd_o.open_word = 1'b1;
          cmd_o.append    = 1'b1;
          cmd_o.add_width = 1'b1;
          state_d         = tglw_pkg::StWrap;
        end else begin
          cmd_o.close_word = 1'b1;
          if (sts_i.is_space) begin
            // A space at the start of a line is dropped.
            if (!sts_i.lw_zero) begin
              cmd_o.append    = 1'b1;
              cmd_o.add_width = 1'b1;
            end
            state_d = tglw_pkg::StWrap;
          end else begin
            cmd_o.start_all = 1'b1;
            ret_d           = tglw_pkg::StNlChar;
            state_d         = tglw_pkg::StAlign;
          end
        end
      end
      tglw_pkg::StNlChar: begin
        cmd_o.newline = sts_i.is_newline;
        state_d       = tglw_pkg::StWrap;
      end
      tglw_pkg::StWrap: begin
        state_d = tglw_pkg::StFull;
        if (!sts_i.wrap_off && sts_i.overflow) begin
          if (!sts_i.word_open) begin
            cmd_o.start_all = 1'b1;
            ret_d           = tglw_pkg::StNlWrap;
            state_d         = tglw_pkg::StAlign;
          end else if (!sts_i.wb_zero) begin
            // Break before the open word.
            cmd_o.start_word = 1'b1;
            ret_d            = tglw_pkg::StNlWrap;
            state_d          = tglw_pkg::StAlign;
          end
        end
      end
      tglw_pkg::StNlWrap: begin
        cmd_o.newline = 1'b1;
        state_d       = tglw_pkg::StFull;
      end
      tglw_pkg::StFull: begin
        if (sts_i.full) begin
          cmd_o.start_all = 1'b1;
          ret_d           = tglw_pkg::StEot;
          state_d         = tglw_pkg::StAlign;
        end else begin
          state_d = tglw_pkg::StEot;
        end
      end
      tglw_pkg::StEot: begin
        if (sts_i.eot) begin
          cmd_o.clear_word = 1'b1;
          cmd_o.start_all  = 1'b1;
          ret_d            = tglw_pkg::StLast;
          state_d          = tglw_pkg::StAlign;
        end else begin
          state_d = tglw_pkg::StLast;
        end
      end
      tglw_pkg::StAlign: begin
        cmd_o.align = 1'b1;
        state_d     = tglw_pkg::StEmit;
      end
      tglw_pkg::StEmit: begin
        if (sts_i.emit_done) begin
          state_d = ret_q;
        end else if (sts_i.can_push) begin
          cmd_o.emit_glyph = 1'b1;
        end
      end
      tglw_pkg::StLast: begin
        // The held glyph goes out marked as the last one of this item.
        if (!sts_i.pend_valid) begin
          state_d = tglw_pkg::StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.flush_last = 1'b1;
          state_d          = tglw_pkg::StIdle;
        end
      end
      default: begin
        state_d = tglw_pkg::StIdle;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tglw_dpath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Glyph layout datapath
// Segment buffer, pen and width state, configuration and output stages.
// ---------------------------------------------------------------------------
module tglw_dpath #(
  parameter int unsigned SEGMENT_MAX = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [2:0]     cfg_idx_i,
  input  wire logic [15:0]    cfg_data_i,
  input  wire tglw_pkg::in_t  in_data_i,
  input  wire logic           out_stall_i,
  output logic                out_valid_o,
  output tglw_pkg::out_t      out_data_o,
  input  wire tglw_pkg::cmd_t cmd_i,
  output tglw_pkg::sts_t      sts_o
);

  localparam int unsigned CW = $clog2(SEGMENT_MAX + 1);
  localparam int unsigned AW = $clog2(SEGMENT_MAX);
  localparam int unsigned PW = CW + 7;

  // Configuration registers. The start y value only loads the pen.
  logic [6:0]  cw_q;
  logic [7:0]  lh_q;
  logic [11:0] ww_q;
  logic [1:0]  am_q;
  logic [15:0] sx_q;

  // Item and layout state.
  logic [7:0]    ch_q;
  logic          eot_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] wb_q, wb_d;
  logic          open_q, open_d;
  logic [15:0]   pen_x_q, pen_x_d;
  logic [15:0]   pen_y_q, pen_y_d;
  logic [15:0]   lw_q, lw_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] emit_n_q, emit_n_d;
  logic [CW-1:0] left_q, left_d;

  // Segment memory and read data.
  logic [6:0]    mem [SEGMENT_MAX];
  logic [6:0]    rd_q;
  logic [AW-1:0] wr_addr;
  logic [CW:0]   wr_sum;
  logic [AW-1:0] head_inc;

  // Hold and output stages.
  tglw_pkg::out_t pend_q, pend_d, out_q, out_d, glyph;
  logic           pend_valid_q, pend_valid_d;
  logic           out_valid_q, out_valid_d;
  logic           out_free, out_push;

  // Arithmetic.
  logic [CW-1:0] mul_n;
  logic [PW-1:0] prod;
  logic [15:0]   prod16, shift;
  logic [16:0]   lw_sum;
  logic [6:0]    glyph_code;

  assign out_free = !out_valid_q || !out_stall_i;

  // Shared multiplier: segment width for alignment or line width after a break.
  assign mul_n  = cmd_i.newline ? count_q : emit_n_q;
  assign prod   = PW'(mul_n) * PW'(cw_q);
  assign prod16 = 16'(prod);

  always_comb begin
    if (am_q == tglw_pkg::AlignMiddle) begin
      shift = prod16 >> 1;
    end else if (am_q == tglw_pkg::AlignRight) begin
      shift = prod16;
    end else begin
      shift = '0;
    end
  end

  // Saturating line width growth.
  assign lw_sum = {1'b0, lw_q} + 17'(cw_q);

  // Circular buffer addressing.
  assign wr_sum   = (CW + 1)'(head_q) + (CW + 1)'(count_q);
  assign wr_addr  = (wr_sum >= (CW + 1)'(SEGMENT_MAX)) ?
                    AW'(wr_sum - (CW + 1)'(SEGMENT_MAX)) : AW'(wr_sum);
  assign head_inc = (head_q == AW'(SEGMENT_MAX - 1)) ? '0 : head_q + 1'b1;
  assign glyph_code = 7'(ch_q - tglw_pkg::GlyphBase);

  assign glyph.glyph_index = rd_q;
  assign glyph.pos_x       = pen_x_q;
  assign glyph.pos_y       = pen_y_q;
  assign glyph.last_glyph  = 1'b0;

  // Next state of the layout registers.
  always_comb begin
    count_d      = count_q;
    wb_d         = wb_q;
    open_d       = open_q;
    pen_x_d      = pen_x_q;
    pen_y_d      = pen_y_q;
    lw_d         = lw_q;
    head_d       = head_q;
    emit_n_d     = emit_n_q;
    left_d       = left_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_push     = 1'b0;

    if (cmd_i.open_word && !open_q) begin
      wb_d = count_q;
    end
    if (cmd_i.open_word) begin
      open_d = 1'b1;
    end
    if (cmd_i.close_word) begin
      open_d = 1'b0;
    end
    if (cmd_i.clear_word) begin
      open_d = 1'b0;
      wb_d   = '0;
    end
    if (cmd_i.append) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.add_width) begin
      lw_d = lw_sum[16] ? 16'hFFFF : lw_sum[15:0];
    end
    if (cmd_i.start_all) begin
      emit_n_d = count_q;
    end
    if (cmd_i.start_word) begin
      emit_n_d = wb_q;
    end
    // Alignment shift and removal of the emitted glyphs from the count.
    if (cmd_i.align) begin
      pen_x_d = pen_x_q - shift;
      count_d = count_q - emit_n_q;
      wb_d    = (wb_q >= emit_n_q) ? wb_q - emit_n_q : '0;
      left_d  = emit_n_q;
    end
    if (cmd_i.newline) begin
      pen_x_d = sx_q;
      pen_y_d = pen_y_q + 16'(lh_q);
      lw_d    = prod16;
    end
    // One glyph per beat unless output stalls; the previous glyph moves to out_q.
    if (cmd_i.emit_glyph) begin
      head_d       = head_inc;
      pen_x_d      = pen_x_q + 16'(cw_q);
      left_d       = left_q - 1'b1;
      pend_d       = glyph;
      pend_valid_d = 1'b1;
      if (pend_valid_q) begin
        out_d    = pend_q;
        out_push = 1'b1;
      end
    end
    if (cmd_i.flush_last) begin
      out_d            = pend_q;
      out_d.last_glyph = 1'b1;
      out_push         = 1'b1;
      pend_valid_d     = 1'b0;
    end

    if (out_push) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    // Configuration writes must arrive only while idle; the block does not check this.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tglw_pkg::RegWrapWidth: begin
          lw_d = '0;
        end
        tglw_pkg::RegStartX: begin
          pen_x_d = cfg_data_i;
          lw_d    = '0;
        end
        tglw_pkg::RegStartY: begin
          pen_y_d = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q         <= tglw_pkg::ResetCharWidth;
      lh_q         <= tglw_pkg::ResetLineHeight;
      ww_q         <= '0;
      am_q         <= '0;
      sx_q         <= '0;
      count_q      <= '0;
      wb_q         <= '0;
      open_q       <= 1'b0;
      pen_x_q      <= '0;
      pen_y_q      <= '0;
      lw_q         <= '0;
      head_q       <= '0;
      emit_n_q     <= '0;
      left_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      wb_q         <= wb_d;
      open_q       <= open_d;
      pen_x_q      <= pen_x_d;
      pen_y_q      <= pen_y_d;
      lw_q         <= lw_d;
      head_q       <= head_d;
      emit_n_q     <= emit_n_d;
      left_q       <= left_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tglw_pkg::RegCharWidth:  cw_q <= cfg_data_i[6:0];
          tglw_pkg::RegLineHeight: lh_q <= cfg_data_i[7:0];
          tglw_pkg::RegWrapWidth:  ww_q <= cfg_data_i[11:0];
          tglw_pkg::RegAlignMode:  am_q <= cfg_data_i[1:0];
          tglw_pkg::RegStartX:     sx_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q  <= in_data_i.char_code;
      eot_q <= in_data_i.end_of_text;
    end
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Segment memory: one write and one registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[wr_addr] <= glyph_code;
    end
    rd_q <= mem[head_d];
  end

  // Status to the controller.
  assign sts_o.printable  = !ch_q[7] && (ch_q[6:5] != 2'b00);
  assign sts_o.is_space   = (ch_q == tglw_pkg::CharSpace);
  assign sts_o.is_word    = sts_o.printable && !sts_o.is_space;
  assign sts_o.is_newline = (ch_q == tglw_pkg::CharNewline);
  assign sts_o.wrap_off   = (ww_q == '0);
  assign sts_o.lw_zero    = (lw_q == '0);
  assign sts_o.overflow   = (lw_q > {4'b0000, ww_q});
  assign sts_o.word_open  = open_q;
  assign sts_o.wb_zero    = (wb_q == '0);
  assign sts_o.full       = (count_q >= CW'(SEGMENT_MAX));
  assign sts_o.eot        = eot_q;
  assign sts_o.emit_done  = (left_q == '0);
  assign sts_o.can_push   = !pend_valid_q || out_free;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_count_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> count_q < CW'(SEGMENT_MAX))
    else $error("segment buffer full when a new character arrives");

  a_word_in_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_q <= count_q)
    else $error("word start lies beyond the buffered segment");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= AW'(SEGMENT_MAX - 1))
    else $error("buffer head out of range");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_glyph && pend_valid_q) || cmd_i.flush_last |-> out_free)
    else $error("glyph pushed into an occupied output register");
`endif

endmodule
`default_nettype wire
